// File: design/life_generation_row_stream_macros.svh
// Assertion macros shared by the row stream design.
`ifndef LIFE_GENERATION_ROW_STREAM_MACROS_SVH
`define LIFE_GENERATION_ROW_STREAM_MACROS_SVH

`ifndef ASSERT_OFF

`define LGRS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define LGRS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define LGRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define LGRS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)

`define LGRS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`define LGRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: design/lgrs_pkg.sv
package lgrs_pkg;

   localparam int DATA_W      = 64;  // row payload width on the ports
   localparam int ROW_W_DFLT  = 64;  // default number of cells
   localparam int COL_W       = 7;   // column count register width
   localparam int CSR_W       = 8;   // column count padded to a byte
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int NCNT_W      = 4;   // neighbor count, 0..8

   localparam logic [NCNT_W-1:0] BIRTH_COUNT   = NCNT_W'(3);
   localparam logic [NCNT_W-1:0] SURVIVE_COUNT = NCNT_W'(2);

   // Bits one cell shows to its neighbors: row above, pending row, new row.
   typedef struct packed {
      logic up;
      logic mid;
      logic dn;
   } tap_type;

   typedef struct packed {
      logic              last;
      logic [DATA_W-1:0] cells;
   } result_type;

   // B3/S23
   function automatic logic life_rule(input logic [NCNT_W-1:0] n, input logic self);
      life_rule = (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && self);
   endfunction

endpackage

// File: design/lgrs_cell.sv
module lgrs_cell import lgrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  logic    last,
   input  logic    live,      // column inside the width in use
   input  logic    row_bit,   // this column of the incoming row
   input  tap_type left,
   input  tap_type right,
   output tap_type tap,
   output logic    next_a,    // next gen of the pending row
   output logic    next_b     // next gen of the incoming row (bottom row)
);

   logic              above_ff, above_in;
   logic              pend_ff, pend_in;
   logic [NCNT_W-1:0] n_a, n_b;

   assign tap.up  = above_ff & live;
   assign tap.mid = pend_ff & live;
   assign tap.dn  = row_bit & live;

   assign n_a = NCNT_W'(left.up) + NCNT_W'(tap.up) + NCNT_W'(right.up)
              + NCNT_W'(left.mid) + NCNT_W'(right.mid)
              + NCNT_W'(left.dn) + NCNT_W'(tap.dn) + NCNT_W'(right.dn);

   // bottom row: pending row above, dead row below
   assign n_b = NCNT_W'(left.mid) + NCNT_W'(tap.mid) + NCNT_W'(right.mid)
              + NCNT_W'(left.dn) + NCNT_W'(right.dn);

   assign next_a = live & life_rule(n_a, tap.mid);
   assign next_b = live & life_rule(n_b, tap.dn);

   always_comb begin
      above_in = above_ff;
      pend_in  = pend_ff;
      if (accept) begin
         if (last) begin
            above_in = 1'b0;
            pend_in  = 1'b0;
         end else begin
            above_in = pend_ff;
            pend_in  = row_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         above_ff <= above_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// File: design/lgrs_out_queue.sv
`include "life_generation_row_stream_macros.svh"

module lgrs_out_queue import lgrs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_n,    // results written this cycle, 0..2
   input  result_type        push0,
   input  result_type        push1,
   output logic              room,      // space for two more results
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,
   output logic              rsp_tlast
);

   result_type        q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              pop;

   assign room       = cnt_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tdata  = q_ff[rd_ff].cells;
   assign rsp_tlast  = q_ff[rd_ff].last;
   assign pop        = rsp_tvalid & rsp_tready;

   always_comb begin
      wr_in  = wr_ff + QPTR_W'(push_n);
      rd_in  = rd_ff + QPTR_W'(pop);
      cnt_in = cnt_ff + QCNT_W'(push_n) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_ff[wr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         q_ff[wr_ff + QPTR_W'(1)] <= push1;
      end
   end

   `LGRS_ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
   `LGRS_ASSERT_IMPLY(a_push_room, clock, reset, push_n != 2'd0, room, "push without room")
   `LGRS_ASSERT_NEXT(a_cnt_track, clock, reset, !pop, cnt_ff == $past(cnt_ff) + $past(push_n), "count lost a push")

endmodule

// File: design/life_generation_row_stream.sv
// One generation of Life (B3/S23) per streamed frame, one row per req transfer.
// Throughput: one row per cycle; req_tready drops only while the 4-entry result
// queue holds more than two results. The bottom row adds one extra result.
// The result for a row is written into the result queue when the row below it is
// taken and leaves it on rsp in order (the bottom row's own result is written right behind it).
// Synchronous active-high reset clears the held rows, the queue and sets 64 columns.
`include "life_generation_row_stream_macros.svh"

module life_generation_row_stream import lgrs_pkg::*; #(
   parameter int ROW_WIDTH = ROW_W_DFLT   // cells in the chain, 3..64
) (
   input  logic              clock,
   input  logic              reset,
   // row input
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [63:0] row_cells
   input  logic              req_tlast,   // final_row
   // next-generation rows
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [63:0] next_row_cells
   output logic              rsp_tlast,   // frame_done
   // column count register
   input  logic              csr_tvalid,
   output logic              csr_tready,
   input  logic [CSR_W-1:0]  csr_tdata    // [6:0] columns_in_use, [7] zero
);

   logic [COL_W-1:0]     cols_ff, cols_in;
   logic [COL_W-1:0]     cols_eff;
   logic                 pend_vld_ff, pend_vld_in;
   logic                 accept;
   logic [ROW_WIDTH-1:0] live;
   logic [ROW_WIDTH-1:0] next_a, next_b;
   tap_type              taps [ROW_WIDTH+2];   // zero taps at both grid edges
   logic                 room;
   logic [1:0]           push_n;
   result_type           res_a, res_b, push0;

   // Register port takes a transfer every cycle; writes must come only when idle (not enforced).
   assign csr_tready = 1'b1;
   assign cols_in    = (csr_tvalid && csr_tready) ? csr_tdata[COL_W-1:0] : cols_ff;

   // Zero acts as one column, anything past the chain as the full chain.
   always_comb begin
      cols_eff = cols_ff;
      if (cols_ff == '0) begin
         cols_eff = COL_W'(1);
      end else if (cols_ff > COL_W'(ROW_WIDTH)) begin
         cols_eff = COL_W'(ROW_WIDTH);
      end
   end

   assign req_tready  = room;
   assign accept      = req_tvalid & req_tready;
   assign pend_vld_in = accept ? !req_tlast : pend_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff     <= COL_W'(DATA_W);
         pend_vld_ff <= 1'b0;
      end else begin
         cols_ff     <= cols_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   // Columns off either end of the chain read as dead.
   assign taps[0]           = '0;
   assign taps[ROW_WIDTH+1] = '0;

   // One cell per column; each holds its bit of the row above and of the pending row
   // and shares those bits and its bit of the incoming row with its two neighbors.
   for (genvar k = 0; k < ROW_WIDTH; k++) begin : g_col
      assign live[k] = COL_W'(k) < cols_eff;

      lgrs_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .accept  (accept),
         .last    (req_tlast),
         .live    (live[k]),
         .row_bit (req_tdata[k]),
         .left    (taps[k]),
         .right   (taps[k+2]),
         .tap     (taps[k+1]),
         .next_a  (next_a[k]),
         .next_b  (next_b[k])
      );
   end

   // Pending row's result goes first, then the bottom row's own result.
   assign res_a.cells = DATA_W'(next_a);
   assign res_a.last  = 1'b0;
   assign res_b.cells = DATA_W'(next_b);
   assign res_b.last  = 1'b1;

   assign push0  = pend_vld_ff ? res_a : res_b;
   assign push_n = accept ? (2'(pend_vld_ff) + 2'(req_tlast)) : 2'd0;

   lgrs_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_n     (push_n),
      .push0      (push0),
      .push1      (res_b),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `LGRS_ASSERT_NEXT(a_last_clears, clock, reset, accept && req_tlast, !pend_vld_ff, "frame end left a pending row")
   `LGRS_ASSERT_NEXT(a_row_holds, clock, reset, accept && !req_tlast, pend_vld_ff, "row not held after transfer")
   `LGRS_ASSERT_IMPLY(a_two_needs_last, clock, reset, push_n == 2'd2, req_tlast && pend_vld_ff, "double push off frame end")

endmodule
